// ----- src/vcfc_pkg.sv -----
package vcfc_pkg;

  localparam int OPCODE_W = 2;
  localparam int POS_XW = 4;
  localparam int POS_YW = 8;
  localparam int POS_ZW = 4;
  localparam int KIND_W = 2;
  localparam int RAW_H_W = 10;
  localparam int HGT_W = 9;
  localparam int FACE_W = 3;
  localparam int WORLD_W = 20;
  localparam int CHUNK_W = 16;
  localparam int PROD_W = 24;
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 16;
  localparam int NUM_FACES = 6;
  localparam int MESH_STEPS = NUM_FACES + 1;
  localparam int STEP_W = 3;
  localparam int GRASS_CELLS = 2;
  localparam int TOPSOIL_CELLS = 6;
  localparam int QDEPTH = 2;

  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FILL  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MESH  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [KIND_W-1:0] KIND_AIR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GRASS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIRT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STONE = 2'd3;

  localparam logic [CFG_IW-1:0] REG_CHUNK_X = 1'b0;
  localparam logic [CFG_IW-1:0] REG_CHUNK_Z = 1'b1;

  localparam int FACE_PX = 0;
  localparam int FACE_NX = 1;
  localparam int FACE_PY = 2;
  localparam int FACE_NY = 3;
  localparam int FACE_PZ = 4;
  localparam int FACE_NZ = 5;

  typedef logic [KIND_W-1:0] kind_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [POS_XW-1:0]   x;
    logic [POS_YW-1:0]   y;
    logic [POS_ZW-1:0]   z;
    kind_t               kind;
    logic [HGT_W-1:0]    height;
    logic [WORLD_W-1:0]  wx;
    logic [WORLD_W-1:0]  wz;
  } cmd_t;

endpackage

// ----- src/vcfc_if.sv -----
interface vcfc_in_if;
  import vcfc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [POS_XW-1:0]          pos_x;
  logic [POS_YW-1:0]          pos_y;
  logic [POS_ZW-1:0]          pos_z;
  logic [KIND_W-1:0]          kind_in;
  logic signed [RAW_H_W-1:0]  raw_height;

  modport source(output valid, opcode, pos_x, pos_y, pos_z, kind_in, raw_height,
                 input ready);
  modport sink(input valid, opcode, pos_x, pos_y, pos_z, kind_in, raw_height,
               output ready);
endinterface

interface vcfc_out_if;
  import vcfc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [FACE_W-1:0]          face;
  logic signed [WORLD_W-1:0]  world_x;
  logic [POS_YW-1:0]          world_y;
  logic signed [WORLD_W-1:0]  world_z;
  logic [KIND_W-1:0]          kind_out;
  logic                       last;

  modport source(output valid, face, world_x, world_y, world_z, kind_out, last,
                 input ready);
  modport sink(input valid, face, world_x, world_y, world_z, kind_out, last,
               output ready);
endinterface

// ----- src/vcfc_front.sv -----
module vcfc_front #(
  parameter int SIDE = 16,
  parameter int TALL = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [vcfc_pkg::CFG_IW-1:0]   wr_index,
  input  logic [vcfc_pkg::CFG_DW-1:0]   wr_data,
  vcfc_in_if.sink                       voxel_ch,
  input  logic                          init_busy,
  output logic                          push_valid,
  input  logic                          push_ready,
  output vcfc_pkg::cmd_t                push_cmd
);
  import vcfc_pkg::*;

  logic signed [CHUNK_W-1:0] chunk_x;
  logic signed [CHUNK_W-1:0] chunk_z;
  logic                      xz_ok;
  logic                      in_range;
  logic                      keep;
  int                        h_int;
  logic [HGT_W-1:0]          h_clamped;
  logic [PROD_W-1:0]         wx_full;
  logic [PROD_W-1:0]         wz_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_x <= '0;
      chunk_z <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CHUNK_X: chunk_x <= wr_data;
        REG_CHUNK_Z: chunk_z <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    xz_ok    = (32'(voxel_ch.pos_x) < 32'(SIDE)) && (32'(voxel_ch.pos_z) < 32'(SIDE));
    in_range = xz_ok && (32'(voxel_ch.pos_y) < 32'(TALL));
    // fill ignores pos_y
    keep = (voxel_ch.opcode == OP_CLEAR) || ((voxel_ch.opcode == OP_FILL) && xz_ok) ||
           in_range;

    h_int = int'(voxel_ch.raw_height);
    if (h_int < 0) begin
      h_clamped = '0;
    end else if (h_int > TALL - 1) begin
      h_clamped = HGT_W'(TALL - 1);
    end else begin
      h_clamped = HGT_W'(h_int);
    end

    wx_full = PROD_W'(chunk_x) * PROD_W'(SIDE) + PROD_W'(voxel_ch.pos_x);
    wz_full = PROD_W'(chunk_z) * PROD_W'(SIDE) + PROD_W'(voxel_ch.pos_z);
  end

  always_comb begin
    push_cmd.op     = voxel_ch.opcode;
    push_cmd.x      = voxel_ch.pos_x;
    push_cmd.y      = voxel_ch.pos_y;
    push_cmd.z      = voxel_ch.pos_z;
    push_cmd.kind   = voxel_ch.kind_in;
    push_cmd.height = h_clamped;
    push_cmd.wx     = wx_full[WORLD_W-1:0];
    push_cmd.wz     = wz_full[WORLD_W-1:0];
  end

  // out-of-chunk items are taken and dropped here
  assign voxel_ch.ready = push_ready && !init_busy;
  assign push_valid     = voxel_ch.valid && !init_busy && keep;

endmodule

// ----- src/vcfc_queue.sv -----
module vcfc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  vcfc_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output vcfc_pkg::cmd_t  pop_cmd
);
  import vcfc_pkg::*;

  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           slots [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;

  assign push_ready = (count != QCW'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QDEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: ;
      endcase
    end
  end

endmodule

// ----- src/vcfc_back.sv -----
module vcfc_back #(
  parameter int SIDE = 16,
  parameter int TALL = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  vcfc_pkg::cmd_t  cmd,
  output logic            init_busy,
  vcfc_out_if.source      face_ch
);
  import vcfc_pkg::*;

  localparam int XW = $clog2(SIDE);
  localparam int YW = $clog2(TALL);
  localparam int AW = 2 * XW + YW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_MESH  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]           state;
  cmd_t                 cur;
  logic [AW-1:0]        sweep;
  logic                 init_q;
  logic [HGT_W-1:0]     fill_d;
  kind_t                fill_kind;
  logic [STEP_W-1:0]    rd_idx;
  logic [STEP_W-1:0]    rd_step_q;
  logic [STEP_W-1:0]    vstep;
  logic                 rd_valid_q;
  kind_t                rd_data;
  kind_t                kind_q;
  logic [NUM_FACES-1:0] bound_m;
  logic [NUM_FACES-1:0] vis;
  logic [NUM_FACES-1:0] pending;
  logic [NUM_FACES-1:0] rem;
  logic [FACE_W-1:0]    sel;
  logic                 out_free;
  logic                 emit_load;
  logic [XW-1:0]        cx;
  logic [YW-1:0]        cy;
  logic [XW-1:0]        cz;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  kind_t                mem_wdata;
  logic [AW-1:0]        mem_raddr;
  kind_t                mem [2**AW];

  logic                 out_valid;
  logic [FACE_W-1:0]    out_face;
  logic [WORLD_W-1:0]   out_wx;
  logic [POS_YW-1:0]    out_wy;
  logic [WORLD_W-1:0]   out_wz;
  kind_t                out_kind;
  logic                 out_last;

  assign cx = XW'(cur.x);
  assign cy = YW'(cur.y);
  assign cz = XW'(cur.z);

  assign init_busy = init_q;
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    bound_m[FACE_PX] = (32'(cur.x) + 32'd1) >= 32'(SIDE);
    bound_m[FACE_NX] = (cur.x == '0);
    bound_m[FACE_PY] = (32'(cur.y) + 32'd1) >= 32'(TALL);
    bound_m[FACE_NY] = (cur.y == '0);
    bound_m[FACE_PZ] = (32'(cur.z) + 32'd1) >= 32'(SIDE);
    bound_m[FACE_NZ] = (cur.z == '0);
  end

  always_comb begin
    if (32'(fill_d) < GRASS_CELLS) begin
      fill_kind = KIND_GRASS;
    end else if (32'(fill_d) < TOPSOIL_CELLS) begin
      fill_kind = KIND_DIRT;
    end else begin
      fill_kind = KIND_STONE;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cx, cy, cz};
    mem_wdata = KIND_AIR;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = cur.kind;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {cx, YW'(cur.height - fill_d), cz};
        mem_wdata = fill_kind;
      end
      default: ;
    endcase
  end

  // neighbor reads: center, then +x -x +y -y +z -z
  always_comb begin
    case (rd_idx)
      3'd1:    mem_raddr = {cx + XW'(1), cy, cz};
      3'd2:    mem_raddr = {cx - XW'(1), cy, cz};
      3'd3:    mem_raddr = {cx, cy + YW'(1), cz};
      3'd4:    mem_raddr = {cx, cy - YW'(1), cz};
      3'd5:    mem_raddr = {cx, cy, cz + XW'(1)};
      3'd6:    mem_raddr = {cx, cy, cz - XW'(1)};
      default: mem_raddr = {cx, cy, cz};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  assign vstep = rd_step_q - STEP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= (state == S_MESH);
    end
  end

  always_ff @(posedge clk) begin
    rd_step_q <= rd_idx;
    if (rd_valid_q) begin
      if (rd_step_q == '0) begin
        kind_q <= rd_data;
      end else begin
        vis[vstep] <= bound_m[vstep] | (rd_data == KIND_AIR);
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (pending[f]) begin
        sel = FACE_W'(f);
      end
    end
  end

  assign rem       = pending & (pending - NUM_FACES'(1));
  assign out_free  = !out_valid || face_ch.ready;
  assign emit_load = (state == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      sweep   <= '0;
      init_q  <= 1'b1;
      rd_idx  <= '0;
      fill_d  <= '0;
      pending <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == '1) begin
            state  <= S_IDLE;
            init_q <= 1'b0;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur    <= cmd;
            fill_d <= '0;
            rd_idx <= '0;
            sweep  <= '0;
            unique case (cmd.op)
              OP_WRITE: state <= S_WRITE;
              OP_FILL:  state <= S_FILL;
              OP_MESH:  state <= S_MESH;
              OP_CLEAR: state <= S_CLEAR;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_WRITE: state <= S_IDLE;
        S_FILL: begin
          fill_d <= fill_d + HGT_W'(1);
          if (fill_d == cur.height) begin
            state <= S_IDLE;
          end
        end
        S_MESH: begin
          rd_idx <= rd_idx + STEP_W'(1);
          if (rd_idx == STEP_W'(MESH_STEPS - 1)) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_EVAL;
        S_EVAL: begin
          if ((kind_q != KIND_AIR) && (vis != '0)) begin
            pending <= vis;
            state   <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            pending <= rem;
            if (rem == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (face_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_face <= sel;
      out_wx   <= cur.wx;
      out_wy   <= cur.y;
      out_wz   <= cur.wz;
      out_kind <= kind_q;
      out_last <= (rem == '0);
    end
  end

  assign face_ch.valid    = out_valid;
  assign face_ch.face     = out_face;
  assign face_ch.world_x  = out_wx;
  assign face_ch.world_y  = out_wy;
  assign face_ch.world_z  = out_wz;
  assign face_ch.kind_out = out_kind;
  assign face_ch.last     = out_last;

  a_no_face_in_init: assert property (@(posedge clk) disable iff (rst)
    init_q |-> !out_valid)
    else $error("face item during init clear");

  a_last_ends_voxel: assert property (@(posedge clk) disable iff (rst)
    (emit_load && (rem == '0)) |=> (state == S_IDLE))
    else $error("last face did not end the voxel");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (pending == '0))
    else $error("faces left pending at idle");

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (pending != '0))
    else $error("emit with no pending face");

  a_read_in_mesh: assert property (@(posedge clk) disable iff (rst)
    rd_valid_q |-> ((state == S_MESH) || (state == S_WAIT)))
    else $error("stray neighbor read data");

endmodule

// ----- src/voxel_chunk_face_culler.sv -----
// Write: the store is updated in the S_WRITE state. Fill: cells from height down to y=0.
// Mesh: seven reads (S_MESH), then S_WAIT, S_EVAL, then one face item per cycle while
//   face_ch.ready is high; the back end takes one voxel at a time, paced by the seven
//   reads on the single voxel memory port. Two queued items let the front keep taking.
// Clear: all 2**(2*clog2(SIDE)+clog2(TALL)) cells (65536 at defaults), one cell a cycle.
// Reset: chunk registers to 0; voxel_ch.ready stays low for the same sweep.
module voxel_chunk_face_culler #(
  parameter int SIDE = 16,
  parameter int TALL = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [vcfc_pkg::CFG_IW-1:0]   wr_index,
  input  logic [vcfc_pkg::CFG_DW-1:0]   wr_data,
  vcfc_in_if.sink                       voxel_ch,
  vcfc_out_if.source                    face_ch
);
  import vcfc_pkg::*;

  logic init_busy;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  vcfc_front #(
    .SIDE(SIDE),
    .TALL(TALL)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .voxel_ch  (voxel_ch),
    .init_busy (init_busy),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  vcfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  vcfc_back #(
    .SIDE(SIDE),
    .TALL(TALL)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(pop_valid),
    .cmd_ready(pop_ready),
    .cmd      (pop_cmd),
    .init_busy(init_busy),
    .face_ch  (face_ch)
  );

endmodule
